>>> hw/rtl/irm_pkg.sv
package irm_pkg;

  localparam int unsigned CNT_W        = 16;
  localparam int unsigned BYTE_IDX_W   = 5;
  localparam int unsigned BIT_IDX_W    = 3;
  localparam int unsigned NUM_BYTES_DEF = 16;

  localparam logic [CNT_W-1:0] PULSE_RST   = 16'd11;
  localparam logic [CNT_W-1:0] TIMEOUT_RST = 16'd200;
  localparam logic [CNT_W-1:0] HALF_RST    = 16'd1;

  // register indexes (byte address = 4 * index)
  localparam logic [1:0] REG_PULSE   = 2'd0;
  localparam logic [1:0] REG_TIMEOUT = 2'd1;
  localparam logic [1:0] REG_HALF    = 2'd2;

  // status codes
  localparam logic [2:0] ST_IDLE    = 3'd0;
  localparam logic [2:0] ST_BUSY    = 3'd1;
  localparam logic [2:0] ST_DONE    = 3'd2;
  localparam logic [2:0] ST_NOT_LOW = 3'd3;
  localparam logic [2:0] ST_TIMEOUT = 3'd4;

  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_PULSE = 3'd1,
    PH_WAIT  = 3'd2,
    PH_HIGH  = 3'd3,
    PH_LOW   = 3'd4
  } phase_t;

  // a register written as zero acts as one
  function automatic logic [CNT_W-1:0] at_least_one(input logic [CNT_W-1:0] v);
    return (v == '0) ? {{(CNT_W-1){1'b0}}, 1'b1} : v;
  endfunction

endpackage

>>> hw/rtl/ir_meter_serial_reader_top.sv
// Serial reader for an infrared meter link, one input beat per timing tick.
// Slave stream: each beat carries the start request and the sampled data
// line for one tick. Master stream: one beat per input beat, giving the
// clock line level for that tick, a received byte when one completes
// (tuser flag), the status code, and tlast with the final byte.
// A start request in idle checks the data line, pulses the clock line high,
// waits for the data line to rise (timeout otherwise), then clocks in
// NUM_BYTES bytes LSB first, sampling on the first tick of each low half.
// A result beat is registered and appears in the cycle after its input beat is taken.
// Throughput: one beat per cycle while the master side accepts; the tick state machine
// and one output register are the whole path.
// Configuration goes through the APB port (pulse length, ready timeout, clock half
// length, in ticks); the user must write it only while the block is idle, unenforced.
// Reset: state goes to idle, counters to zero, registers to 11, 200, 1;
// no output beat is pending.
// When the master side stalls, the held output beat stays in place and
// s_tready drops; no tick is consumed until the beat is taken.
module ir_meter_serial_reader_top #(
  parameter int unsigned NUM_BYTES = irm_pkg::NUM_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // APB configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // input ticks
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [0] start_request, [1] data_line, [7:2] zero
  // results
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [0] clock_line, [8:1] byte_value, [15:9] zero
  output logic [3:0]  m_tuser,   // [0] byte_valid, [3:1] status_code
  output logic        m_tlast    // last_byte
);

  localparam int unsigned CW = irm_pkg::CNT_W;
  localparam int unsigned BW = irm_pkg::BYTE_IDX_W;
  localparam int unsigned IW = irm_pkg::BIT_IDX_W;

  // configuration registers
  logic [CW-1:0] start_pulse_ticks;
  logic [CW-1:0] ready_timeout_ticks;
  logic [CW-1:0] clock_half_ticks;

  logic cfg_wr;
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_pulse_ticks   <= irm_pkg::PULSE_RST;
      ready_timeout_ticks <= irm_pkg::TIMEOUT_RST;
      clock_half_ticks    <= irm_pkg::HALF_RST;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        irm_pkg::REG_PULSE:   start_pulse_ticks   <= pwdata[CW-1:0];
        irm_pkg::REG_TIMEOUT: ready_timeout_ticks <= pwdata[CW-1:0];
        irm_pkg::REG_HALF:    clock_half_ticks    <= pwdata[CW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      irm_pkg::REG_PULSE:   prdata = {{(32-CW){1'b0}}, start_pulse_ticks};
      irm_pkg::REG_TIMEOUT: prdata = {{(32-CW){1'b0}}, ready_timeout_ticks};
      irm_pkg::REG_HALF:    prdata = {{(32-CW){1'b0}}, clock_half_ticks};
      default:              prdata = '0;
    endcase
  end

  // tick state
  irm_pkg::phase_t phase, phase_next;
  logic [CW-1:0]   tick_counter, tick_counter_next;
  logic [IW-1:0]   bit_index, bit_index_next;
  logic [BW-1:0]   byte_index, byte_index_next;
  logic [7:0]      shift_byte, shift_byte_next;

  logic out_valid;
  logic tick_acc, out_acc;

  assign s_tready = !out_valid || m_tready;
  assign tick_acc = s_tvalid && s_tready;
  assign out_acc  = m_tvalid && m_tready;

  logic req, dl;
  assign req = s_tdata[0];
  assign dl  = s_tdata[1];

  logic [CW-1:0] pulse, tmo, half, tc_inc;
  assign pulse  = irm_pkg::at_least_one(start_pulse_ticks);
  assign tmo    = irm_pkg::at_least_one(ready_timeout_ticks);
  assign half   = irm_pkg::at_least_one(clock_half_ticks);
  assign tc_inc = tick_counter + {{(CW-1){1'b0}}, 1'b1};

  // bit sample of the low half
  logic       sample_now, byte_full, final_byte;
  logic [7:0] sampled;
  always_comb begin
    sampled = shift_byte;
    sampled[bit_index] = dl;
  end
  assign sample_now = (phase == irm_pkg::PH_LOW) && (tick_counter == '0);
  assign byte_full  = sample_now && (bit_index == {IW{1'b1}});
  assign final_byte = byte_full &&
                      (({1'b0, byte_index} + {{BW{1'b0}}, 1'b1}) >= (BW+1)'(NUM_BYTES));

  // next state
  always_comb begin
    phase_next        = phase;
    tick_counter_next = tick_counter;
    bit_index_next    = bit_index;
    byte_index_next   = byte_index;
    shift_byte_next   = shift_byte;
    unique case (phase)
      irm_pkg::PH_PULSE: begin
        tick_counter_next = tc_inc;
        if (tc_inc >= pulse) begin
          phase_next        = irm_pkg::PH_WAIT;
          tick_counter_next = '0;
        end
      end
      irm_pkg::PH_WAIT: begin
        if (dl) begin
          phase_next        = irm_pkg::PH_HIGH;
          tick_counter_next = '0;
        end else begin
          tick_counter_next = tc_inc;
          if (tc_inc >= tmo) begin
            phase_next        = irm_pkg::PH_IDLE;
            tick_counter_next = '0;
          end
        end
      end
      irm_pkg::PH_HIGH: begin
        tick_counter_next = tc_inc;
        if (tc_inc >= half) begin
          phase_next        = irm_pkg::PH_LOW;
          tick_counter_next = '0;
        end
      end
      irm_pkg::PH_LOW: begin
        if (sample_now) begin
          shift_byte_next = sampled;
          bit_index_next  = bit_index + {{(IW-1){1'b0}}, 1'b1};
          if (byte_full) begin
            shift_byte_next = '0;
            byte_index_next = byte_index + {{(BW-1){1'b0}}, 1'b1};
          end
        end
        tick_counter_next = tc_inc;
        if (tc_inc >= half) begin
          phase_next        = irm_pkg::PH_HIGH;
          tick_counter_next = '0;
        end
        if (final_byte) begin
          phase_next        = irm_pkg::PH_IDLE;
          tick_counter_next = '0;
          byte_index_next   = '0;
        end
      end
      default: begin
        phase_next = irm_pkg::PH_IDLE;
        if (req && !dl) begin
          bit_index_next  = '0;
          byte_index_next = '0;
          shift_byte_next = '0;
          if (pulse == {{(CW-1){1'b0}}, 1'b1}) begin
            phase_next        = irm_pkg::PH_WAIT;
            tick_counter_next = '0;
          end else begin
            phase_next        = irm_pkg::PH_PULSE;
            tick_counter_next = {{(CW-1){1'b0}}, 1'b1};
          end
        end
      end
    endcase
  end

  // result fields for this tick
  logic       clock_next, valid_next, last_next;
  logic [7:0] bval_next;
  logic [2:0] status_next;
  always_comb begin
    clock_next  = 1'b0;
    valid_next  = 1'b0;
    bval_next   = '0;
    last_next   = 1'b0;
    status_next = irm_pkg::ST_BUSY;
    unique case (phase) inside
      irm_pkg::PH_PULSE, irm_pkg::PH_HIGH: clock_next = 1'b1;
      irm_pkg::PH_WAIT: begin
        if (!dl && tc_inc >= tmo) status_next = irm_pkg::ST_TIMEOUT;
      end
      irm_pkg::PH_LOW: begin
        if (byte_full) begin
          valid_next = 1'b1;
          bval_next  = sampled;
        end
        if (final_byte) begin
          last_next   = 1'b1;
          status_next = irm_pkg::ST_DONE;
        end
      end
      default: begin
        status_next = irm_pkg::ST_IDLE;
        if (req) begin
          if (dl) begin
            status_next = irm_pkg::ST_NOT_LOW;
          end else begin
            status_next = irm_pkg::ST_BUSY;
            clock_next  = 1'b1;
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= irm_pkg::PH_IDLE;
      tick_counter <= '0;
      bit_index    <= '0;
      byte_index   <= '0;
      shift_byte   <= '0;
    end else if (tick_acc) begin
      phase        <= phase_next;
      tick_counter <= tick_counter_next;
      bit_index    <= bit_index_next;
      byte_index   <= byte_index_next;
      shift_byte   <= shift_byte_next;
    end
  end

  // output register
  logic       out_clock, out_bvalid, out_last;
  logic [7:0] out_byte;
  logic [2:0] out_status;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (tick_acc) begin
      out_valid <= 1'b1;
    end else if (out_acc) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (tick_acc) begin
      out_clock  <= clock_next;
      out_bvalid <= valid_next;
      out_byte   <= bval_next;
      out_last   <= last_next;
      out_status <= status_next;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {7'd0, out_byte, out_clock};
  assign m_tuser  = {out_status, out_bvalid};
  assign m_tlast  = out_last;

  // the final byte beat is always a completed byte with done status
  a_last_is_done: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_last) |-> (out_bvalid && out_status == irm_pkg::ST_DONE))
    else $error("last byte beat without byte or done status");

  // every ending status leaves the state machine idle
  a_end_to_idle: assert property (@(posedge clk) disable iff (rst)
    (tick_acc && (status_next == irm_pkg::ST_DONE || status_next == irm_pkg::ST_TIMEOUT ||
                  status_next == irm_pkg::ST_NOT_LOW)) |=> (phase == irm_pkg::PH_IDLE))
    else $error("transaction end did not return to idle");

  a_byte_index_range: assert property (@(posedge clk) disable iff (rst)
    ({1'b0, byte_index} < (BW+1)'(NUM_BYTES)))
    else $error("byte index past the transaction length");

endmodule
